@@ rtl/qsl_pkg.sv @@
`default_nettype none
package qsl_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int TRIG_ITER  = 16;
    localparam int SQ_N       = 31;   // root bits of a 62 bit radicand
    localparam int DIV_N      = 32;   // quotient bits

    localparam logic [14:0] ONE           = 15'd16384;
    localparam logic [14:0] THR_RESET     = 15'd16376;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic [31:0] WEIGHT_MAX    = 32'h8000_0000;

    // pipeline stage positions
    localparam int ST_A   = 0;               // products
    localparam int ST_B   = 1;               // dot sum
    localparam int ST_C   = 2;               // fold, round, clamp, path pick
    localparam int ST_D   = 3;               // radicand
    localparam int ST_SQ  = ST_D + SQ_N;     // last root cell
    localparam int ST_VEC = ST_SQ + TRIG_ITER;
    localparam int ST_M   = ST_VEC + 1;      // blend angles
    localparam int ST_SIN = ST_M + TRIG_ITER;
    localparam int ST_P   = ST_SIN + 1;      // divider set-up
    localparam int ST_DIV = ST_P + DIV_N;
    localparam int ST_W   = ST_DIV + 1;      // weight clamp
    localparam int ST_X   = ST_W + 1;        // output products
    localparam int LAT    = ST_X + 1;

    typedef struct packed {
        logic [3:0][16:0] s;
        logic [3:0][15:0] e;
        logic [14:0]      t;
        logic [14:0]      d;
        logic             lin;
        logic             sat0;
        logic             sat1;
    } side_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic               lin;
    } res_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0: r = 34'sd843314856;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043836;
            5'd3: r = 34'sd133525158;
            5'd4: r = 34'sd67021686;
            5'd5: r = 34'sd33543515;
            5'd6: r = 34'sd16775850;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194282;
            5'd9: r = 34'sd2097149;
            default: r = (i <= 5'd30) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd16384)
            r = 16'sd16384;
        else if (v < -24'sd16384)
            r = -16'sd16384;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/qsl_if.sv @@
`default_nettype none
interface qsl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] start_w;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic signed [15:0] end_w;
    logic [14:0]        blend;

    modport source (output valid, start_x, start_y, start_z, start_w,
                    end_x, end_y, end_z, end_w, blend, input ready);
    modport sink (input valid, start_x, start_y, start_z, start_w,
                  end_x, end_y, end_z, end_w, blend, output ready);
endinterface

interface qsl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
    logic               used_linear;

    modport source (output valid, out_x, out_y, out_z, out_w, used_linear,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, used_linear,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/qsl_sqrt_cell.sv @@
`default_nettype none
module qsl_sqrt_cell (
    input  wire logic  clk,
    input  logic       en,
    input  logic [33:0] rem_in,
    input  logic [30:0] root_in,
    input  logic [61:0] rad_in,
    output logic [33:0] rem_out,
    output logic [30:0] root_out,
    output logic [61:0] rad_out
);
    logic [35:0] cur;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    logic [33:0] rem_reg, rem_next;
    logic [30:0] root_reg, root_next;
    logic [61:0] rad_reg, rad_next;

    // one root bit per cell
    always_comb
    begin
        cur       = {rem_in, rad_in[61:60]};
        trial     = {3'b000, root_in, 2'b01};
        diff      = cur - trial;
        ge        = (cur >= trial);
        rem_next  = ge ? diff[33:0] : cur[33:0];
        root_next = {root_in[29:0], ge};
        rad_next  = {rad_in[59:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;
endmodule
`default_nettype wire

@@ rtl/qsl_vec_cell.sv @@
`default_nettype none
module qsl_vec_cell (
    input  wire logic         clk,
    input  logic              en,
    input  logic [4:0]        step,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);
    logic signed [33:0] xs, ys, at;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;

    // vectoring: drive y towards zero
    always_comb
    begin
        xs = x_in >>> step;
        ys = y_in >>> step;
        at = qsl_pkg::atan_q30(step);
        if (!y_in[33])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

@@ rtl/qsl_rot_cell.sv @@
`default_nettype none
module qsl_rot_cell (
    input  wire logic         clk,
    input  logic              en,
    input  logic [4:0]        step,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);
    logic signed [33:0] xs, ys, at;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;

    // rotation: drive the residual angle towards zero
    always_comb
    begin
        xs = x_in >>> step;
        ys = y_in >>> step;
        at = qsl_pkg::atan_q30(step);
        if (!z_in[33])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

@@ rtl/qsl_div_cell.sv @@
`default_nettype none
module qsl_div_cell (
    input  wire logic  clk,
    input  logic       en,
    input  logic [31:0] rem_in,
    input  logic [31:0] q_in,
    input  logic [31:0] feed_in,
    input  logic [31:0] den_in,
    output logic [31:0] rem_out,
    output logic [31:0] q_out,
    output logic [31:0] feed_out,
    output logic [31:0] den_out
);
    logic [32:0] cur;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] feed_reg, feed_next;
    logic [31:0] den_reg;

    // restoring step, one quotient bit
    always_comb
    begin
        cur       = {rem_in, feed_in[31]};
        diff      = cur - {1'b0, den_in};
        ge        = (cur >= {1'b0, den_in});
        rem_next  = ge ? diff[31:0] : cur[31:0];
        q_next    = {q_in[30:0], ge};
        feed_next = {feed_in[30:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            feed_reg <= feed_next;
            den_reg  <= den_in;
        end
    end

    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign feed_out = feed_reg;
    assign den_out  = den_reg;
endmodule
`default_nettype wire

@@ rtl/quaternion_slerp_unit.sv @@
// quaternion slerp unit, signed q2.14 in and out
// in_ch carries one beat per quaternion pair plus the blend fraction; out_ch
// returns one beat per input beat, in order, with the interpolated quaternion
// and a flag telling whether the linear blend was used.
// cfg_wr_en / cfg_wr_data write the lerp threshold; write it only while idle.
// throughput: one beat per cycle while out_ch does not stall the chain.
// a result is registered at the end of a chain of one-step cells: 31
// square-root cells, 16 vectoring cordic cells for acos, three parallel rows
// of 16 rotation cells for the sines and two rows of 32 divider cells for the
// weights, plus the arithmetic stages around them (products, dot sum, fold,
// radicand, blend angles, divider set-up, weight clamp, output products).
// the whole chain moves in lockstep; it holds only when a finished beat sits
// in the output register, the last stage is occupied and out_ch.ready is low.
// until then new beats keep being taken and bubbles are squeezed out.
// reset clears all valid flags, the output valid included, and loads the
// threshold with 16376.
`default_nettype none
module quaternion_slerp_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    qsl_in_if.sink           in_ch,
    qsl_out_if.source        out_ch,
    input  logic             cfg_wr_en,
    input  logic [14:0]      cfg_wr_data
);
    localparam int LAT  = qsl_pkg::LAT;
    localparam int TRIG = qsl_pkg::TRIG_ITER;
    localparam int SQN  = qsl_pkg::SQ_N;
    localparam int DVN  = qsl_pkg::DIV_N;

    // control
    logic [14:0]     thr_reg;
    logic [LAT-1:0]  v_reg;
    logic            out_valid_reg;
    logic            adv;
    qsl_pkg::res_t   out_reg, out_next;

    // sideband travelling with every stage
    qsl_pkg::side_t  side_reg  [0:LAT-1];
    qsl_pkg::side_t  side_next [0:LAT-1];

    // stage data
    logic signed [31:0] prod_reg [4];
    logic signed [33:0] dot_reg;
    logic [61:0]        rad_reg;
    logic signed [33:0] th_reg, a0_reg, a1_reg;
    logic [31:0]        drem_reg [2];
    logic [31:0]        dfeed_reg [2];
    logic [31:0]        den_reg;
    logic [31:0]        w_reg [2];
    logic signed [49:0] pw0_reg [4];
    logic signed [49:0] pw1_reg [4];
    logic signed [32:0] pl0_reg [4];
    logic signed [32:0] pl1_reg [4];

    // input unpacking
    logic signed [15:0] qs_in [4];
    logic signed [15:0] qe_in [4];
    logic [14:0]        t_in;

    // chains
    logic [33:0]        sq_rem  [0:SQN];
    logic [30:0]        sq_root [0:SQN];
    logic [61:0]        sq_rad  [0:SQN];
    logic signed [33:0] vx [0:TRIG];
    logic signed [33:0] vy [0:TRIG];
    logic signed [33:0] vz [0:TRIG];
    logic signed [33:0] rx [0:2][0:TRIG];
    logic signed [33:0] ry [0:2][0:TRIG];
    logic signed [33:0] rz [0:2][0:TRIG];
    logic [31:0]        dr  [0:1][0:DVN];
    logic [31:0]        dq  [0:1][0:DVN];
    logic [31:0]        dfd [0:1][0:DVN];
    logic [31:0]        dd  [0:1][0:DVN];

    // combinational helpers
    logic signed [33:0] dabs;
    logic [34:0]        drnd;
    logic [20:0]        dq14;
    logic [14:0]        dcl;
    logic [29:0]        dsq;
    logic [14:0]        t_m;
    logic [14:0]        omt_m;
    logic [46:0]        a0_prod, a1_prod;
    logic signed [33:0] sin_t;
    logic [31:0]        sin_a [2];
    logic [31:0]        q_fin [2];
    logic [14:0]        omt_x;

    // the pipe holds only when a finished beat waits and the tail is full
    assign adv         = !v_reg[LAT-1] || !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    assign qs_in[0] = in_ch.start_x;
    assign qs_in[1] = in_ch.start_y;
    assign qs_in[2] = in_ch.start_z;
    assign qs_in[3] = in_ch.start_w;
    assign qe_in[0] = in_ch.end_x;
    assign qe_in[1] = in_ch.end_y;
    assign qe_in[2] = in_ch.end_z;
    assign qe_in[3] = in_ch.end_w;
    assign t_in     = (in_ch.blend > qsl_pkg::ONE) ? qsl_pkg::ONE : in_ch.blend;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= qsl_pkg::THR_RESET;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            if (adv)
                v_reg <= {v_reg[LAT-2:0], in_ch.valid};
            if (adv && v_reg[LAT-1])
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // sideband: shift, with edits at the fold stage and the divider set-up
    always_comb
    begin
        dabs = dot_reg[33] ? -dot_reg : dot_reg;
        drnd = {1'b0, dabs} + 35'd8192;
        dq14 = drnd[34:14];
        dcl  = (dq14 > {6'd0, qsl_pkg::ONE}) ? qsl_pkg::ONE : dq14[14:0];

        sin_t    = ry[0][TRIG];
        sin_a[0] = ry[1][TRIG][33] ? 32'd0 : ry[1][TRIG][31:0];
        sin_a[1] = ry[2][TRIG][33] ? 32'd0 : ry[2][TRIG][31:0];

        for (int k = 0; k < 4; k++)
        begin
            side_next[0].s[k] = {qs_in[k][15], qs_in[k]};
            side_next[0].e[k] = qe_in[k];
        end
        side_next[0].t    = t_in;
        side_next[0].d    = '0;
        side_next[0].lin  = 1'b0;
        side_next[0].sat0 = 1'b0;
        side_next[0].sat1 = 1'b0;
        for (int k = 1; k < LAT; k++)
            side_next[k] = side_reg[k-1];

        // fold start onto the near hemisphere
        for (int k = 0; k < 4; k++)
            side_next[qsl_pkg::ST_C].s[k] = dot_reg[33] ? -side_reg[qsl_pkg::ST_B].s[k]
                                                        :  side_reg[qsl_pkg::ST_B].s[k];
        side_next[qsl_pkg::ST_C].d   = dcl;
        side_next[qsl_pkg::ST_C].lin = (dcl >= thr_reg) || (dcl == qsl_pkg::ONE);

        // sin(theta) not positive falls back to linear; flag oversize weights
        side_next[qsl_pkg::ST_P].lin  = side_reg[qsl_pkg::ST_P-1].lin || (sin_t <= 34'sd0);
        side_next[qsl_pkg::ST_P].sat0 = {2'b00, sin_a[0]} >= {sin_t[31:0], 2'b00};
        side_next[qsl_pkg::ST_P].sat1 = {2'b00, sin_a[1]} >= {sin_t[31:0], 2'b00};
    end

    // stage arithmetic
    always_comb
    begin
        dsq     = side_reg[qsl_pkg::ST_C].d * side_reg[qsl_pkg::ST_C].d;
        t_m     = side_reg[qsl_pkg::ST_VEC].t;
        omt_m   = qsl_pkg::ONE - t_m;
        a0_prod = omt_m * vz[TRIG][31:0];
        a1_prod = t_m * vz[TRIG][31:0];
        for (int c = 0; c < 2; c++)
            q_fin[c] = dq[c][DVN];
        omt_x   = qsl_pkg::ONE - side_reg[qsl_pkg::ST_W].t;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LAT; k++)
                side_reg[k] <= side_next[k];

            for (int k = 0; k < 4; k++)
                prod_reg[k] <= qs_in[k] * qe_in[k];

            dot_reg <= 34'(prod_reg[0]) + 34'(prod_reg[1])
                     + 34'(prod_reg[2]) + 34'(prod_reg[3]);

            // 1 - d^2 in q60
            rad_reg <= (62'd1 << 60) - {dsq, 32'd0};

            // theta and the two blend angles, truncated to q30
            th_reg <= vz[TRIG];
            a0_reg <= $signed({3'b000, a0_prod[44:14]});
            a1_reg <= $signed({3'b000, a1_prod[44:14]});

            for (int c = 0; c < 2; c++)
            begin
                drem_reg[c]  <= {2'b00, sin_a[c][31:2]};
                dfeed_reg[c] <= {sin_a[c][1:0], 30'd0};
            end
            den_reg <= sin_t[31:0];

            w_reg[0] <= (side_reg[qsl_pkg::ST_DIV].sat0 || q_fin[0] > qsl_pkg::WEIGHT_MAX)
                        ? qsl_pkg::WEIGHT_MAX : q_fin[0];
            w_reg[1] <= (side_reg[qsl_pkg::ST_DIV].sat1 || q_fin[1] > qsl_pkg::WEIGHT_MAX)
                        ? qsl_pkg::WEIGHT_MAX : q_fin[1];

            for (int k = 0; k < 4; k++)
            begin
                pw0_reg[k] <= $signed({1'b0, w_reg[0]})
                            * $signed(side_reg[qsl_pkg::ST_W].s[k]);
                pw1_reg[k] <= 50'($signed({1'b0, w_reg[1]})
                            * $signed(side_reg[qsl_pkg::ST_W].e[k]));
                pl0_reg[k] <= $signed({1'b0, omt_x})
                            * $signed(side_reg[qsl_pkg::ST_W].s[k]);
                pl1_reg[k] <= 33'($signed({1'b0, side_reg[qsl_pkg::ST_W].t})
                            * $signed(side_reg[qsl_pkg::ST_W].e[k]));
            end

            if (v_reg[LAT-1])
                out_reg <= out_next;
        end
    end

    // final sums, round half up, saturate
    always_comb
    begin
        logic signed [50:0] ssum;
        logic signed [33:0] lsum;
        logic signed [15:0] r [4];
        for (int k = 0; k < 4; k++)
        begin
            ssum = 51'(pw0_reg[k]) + 51'(pw1_reg[k]) + 51'sd536870912;
            lsum = 34'(pl0_reg[k]) + 34'(pl1_reg[k]) + 34'sd8192;
            if (side_reg[qsl_pkg::ST_X].lin)
                r[k] = qsl_pkg::sat16({{4{lsum[33]}}, lsum[33:14]});
            else
                r[k] = qsl_pkg::sat16({{3{ssum[50]}}, ssum[50:30]});
        end
        out_next.x   = r[0];
        out_next.y   = r[1];
        out_next.z   = r[2];
        out_next.w   = r[3];
        out_next.lin = side_reg[qsl_pkg::ST_X].lin;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_x       = out_reg.x;
    assign out_ch.out_y       = out_reg.y;
    assign out_ch.out_z       = out_reg.z;
    assign out_ch.out_w       = out_reg.w;
    assign out_ch.used_linear = out_reg.lin;

    // square root of 1 - d^2
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = rad_reg;

    for (genvar j = 0; j < SQN; j++)
    begin : g_sqrt
        qsl_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .rad_in   (sq_rad[j]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1]),
            .rad_out  (sq_rad[j+1])
        );
    end

    // acos via atan2(sqrt(1-d^2), d)
    assign vx[0] = $signed({3'b000, side_reg[qsl_pkg::ST_SQ].d, 16'd0});
    assign vy[0] = $signed({3'b000, sq_root[SQN]});
    assign vz[0] = '0;

    for (genvar j = 0; j < TRIG; j++)
    begin : g_vec
        qsl_vec_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .step  (5'(j)),
            .x_in  (vx[j]),
            .y_in  (vy[j]),
            .z_in  (vz[j]),
            .x_out (vx[j+1]),
            .y_out (vy[j+1]),
            .z_out (vz[j+1])
        );
    end

    // sines of theta, (1-t)theta and t theta side by side
    assign rz[0][0] = th_reg;
    assign rz[1][0] = a0_reg;
    assign rz[2][0] = a1_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_sin_row
        assign rx[c][0] = qsl_pkg::CORDIC_K;
        assign ry[c][0] = '0;
        for (genvar j = 0; j < TRIG; j++)
        begin : g_sin
            qsl_rot_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .step  (5'(j)),
                .x_in  (rx[c][j]),
                .y_in  (ry[c][j]),
                .z_in  (rz[c][j]),
                .x_out (rx[c][j+1]),
                .y_out (ry[c][j+1]),
                .z_out (rz[c][j+1])
            );
        end
    end

    // weights: sin(angle) * 2^30 / sin(theta)
    for (genvar c = 0; c < 2; c++)
    begin : g_div_row
        assign dr[c][0]  = drem_reg[c];
        assign dq[c][0]  = '0;
        assign dfd[c][0] = dfeed_reg[c];
        assign dd[c][0]  = den_reg;
        for (genvar j = 0; j < DVN; j++)
        begin : g_div
            qsl_div_cell u_cell (
                .clk      (clk),
                .en       (adv),
                .rem_in   (dr[c][j]),
                .q_in     (dq[c][j]),
                .feed_in  (dfd[c][j]),
                .den_in   (dd[c][j]),
                .rem_out  (dr[c][j+1]),
                .q_out    (dq[c][j+1]),
                .feed_out (dfd[c][j+1]),
                .den_out  (dd[c][j+1])
            );
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    // one input beat: start and end quaternions plus blend fraction
    typedef struct {
        logic signed [15:0] s [4];
        logic signed [15:0] e [4];
        logic [14:0]        t;
        bit                 typed;   // expected result typed into the table
        qsl_pkg::res_t      res;
    } pair_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;

    qsl_in_if  in_ch ();
    qsl_out_if out_ch ();

    quaternion_slerp_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    qsl_pkg::res_t slerp_q [$];   // results still owed by the block, oldest first
    pair_t       directed [$];
    logic [14:0] threshold;       // our copy of the lerp threshold
    int          errors;
    bit          calm_in;         // stretch with no gaps on the input side
    bit          calm_out;        // stretch with no stalls on the output side

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous fixed limit, far above the slowest correct run
    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor: fixed-point slerp, bit for bit
    // ---------------------------------------------------------------
    function automatic longint atan_step(int i);
        longint head [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                              33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10)
            return head[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic on (d, sqrt(1-d^2)), angle in q30
    function automatic longint arccos_q30(longint d);
        longint x = d <<< 16;
        longint y;
        longint z = 0;
        longint xs;
        longint ys;
        y = longint'(root64((64'h1 << 60) - longint'(x * x)));
        for (int i = 0; i < qsl_pkg::TRIG_ITER; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint sine_q30(longint z);
        longint x = 652032874;
        longint y = 0;
        longint xs;
        longint ys;
        for (int i = 0; i < qsl_pkg::TRIG_ITER; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        return y;
    endfunction

    function automatic longint blend_weight(longint sa, longint st);
        longint unsigned w;
        if (sa < 0)
            sa = 0;
        w = (longint'(sa) << 30) / longint'(st);
        return (w > (64'h1 << 31)) ? (longint'(1) << 31) : longint'(w);
    endfunction

    function automatic logic signed [15:0] clip_q14(longint v);
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v[15:0];
    endfunction

    function automatic qsl_pkg::res_t slerp_predict(pair_t p, logic [14:0] thr);
        longint one = 16384;
        longint s [4];
        longint e [4];
        longint dot = 0;
        longint t;
        longint theta;
        longint sin_th;
        longint w0;
        longint w1;
        longint o [4];
        bit     lin;
        qsl_pkg::res_t r;
        for (int k = 0; k < 4; k++)
        begin
            s[k] = p.s[k];
            e[k] = p.e[k];
            dot += s[k] * e[k];
        end
        t = p.t;
        if (t > one)
            t = one;
        // take the short way round: flip start when the dot is negative
        if (dot < 0)
        begin
            dot = -dot;
            for (int k = 0; k < 4; k++)
                s[k] = -s[k];
        end
        dot = (dot + 8192) >>> 14;
        if (dot > one)
            dot = one;
        lin = (dot >= longint'(thr)) || (dot == one);
        if (!lin)
        begin
            theta  = arccos_q30(dot);
            sin_th = sine_q30(theta);
            if (sin_th <= 0)
                lin = 1'b1;
            else
            begin
                w0 = blend_weight(sine_q30(((one - t) * theta) >>> 14), sin_th);
                w1 = blend_weight(sine_q30((t * theta) >>> 14), sin_th);
                for (int k = 0; k < 4; k++)
                    o[k] = (w0 * s[k] + w1 * e[k] + (longint'(1) << 29)) >>> 30;
            end
        end
        if (lin)
            for (int k = 0; k < 4; k++)
                o[k] = ((one - t) * s[k] + t * e[k] + 8192) >>> 14;
        r.x   = clip_q14(o[0]);
        r.y   = clip_q14(o[1]);
        r.z   = clip_q14(o[2]);
        r.w   = clip_q14(o[3]);
        r.lin = lin;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic signed [15:0] rand_comp();
        int v;
        case ($urandom_range(9))
            0: v = 16384;
            1: v = -16384;
            2: v = 0;
            default: v = int'($urandom_range(32768)) - 16384;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [14:0] rand_blend();
        case ($urandom_range(9))
            0: return 15'd0;
            1: return qsl_pkg::ONE;
            2: return 15'($urandom_range(32767, 16385));   // saturates to one
            default: return 15'($urandom_range(16384));
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int    v;
        int    d;
        int    kind;
        kind = $urandom_range(9);
        d    = (kind < 4) ? 16 : 2048;
        for (int k = 0; k < 4; k++)
        begin
            p.s[k] = rand_comp();
            if (kind >= 8)
                p.e[k] = rand_comp();             // unrelated pair
            else
            begin
                // end close to start, sometimes on the far side
                v = int'(p.s[k]) + int'($urandom_range(2 * d)) - d;
                if (kind == 7)
                    v = -v;
                if (v > 16384)
                    v = 16384;
                if (v < -16384)
                    v = -16384;
                p.e[k] = v[15:0];
            end
        end
        p.t     = rand_blend();
        p.typed = 1'b0;
        p.res   = '0;
        return p;
    endfunction

    function automatic pair_t row(int sx, int sy, int sz, int sw, int ex, int ey, int ez, int ew,
                                  int t, bit typed, int ox, int oy, int oz, int ow, bit lin);
        pair_t p;
        p.s     = '{sx[15:0], sy[15:0], sz[15:0], sw[15:0]};
        p.e     = '{ex[15:0], ey[15:0], ez[15:0], ew[15:0]};
        p.t     = t[14:0];
        p.typed = typed;
        p.res.x = ox[15:0];
        p.res.y = oy[15:0];
        p.res.z = oz[15:0];
        p.res.w = ow[15:0];
        p.res.lin = lin;
        return p;
    endfunction

    // one input beat with a random gap in front; no gap keeps valid high
    task automatic send_pair(pair_t p);
        int gap;
        if (calm_in)
            gap = 0;
        else if ($urandom_range(19) == 0)
            gap = $urandom_range(40, 5);
        else
            gap = $urandom_range(2);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.start_x <= p.s[0];
        in_ch.start_y <= p.s[1];
        in_ch.start_z <= p.s[2];
        in_ch.start_w <= p.s[3];
        in_ch.end_x   <= p.e[0];
        in_ch.end_y   <= p.e[1];
        in_ch.end_z   <= p.e[2];
        in_ch.end_w   <= p.e[3];
        in_ch.blend   <= p.t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // beat taken at this edge
        slerp_q.push_back(p.typed ? p.res : slerp_predict(p, threshold));
    endtask

    // threshold write, only with the pipeline drained
    task automatic set_threshold(logic [14:0] v);
        in_ch.valid <= 1'b0;
        while (slerp_q.size() != 0)
            @(posedge clk);
        repeat (qsl_pkg::LAT + 8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        threshold = v;
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls and checking against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        qsl_pkg::res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (slerp_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = slerp_q.pop_front();
                if (out_ch.out_x !== want.x)
                begin
                    $error("out_x expected %0d got %0d", want.x, out_ch.out_x);
                    errors++;
                end
                if (out_ch.out_y !== want.y)
                begin
                    $error("out_y expected %0d got %0d", want.y, out_ch.out_y);
                    errors++;
                end
                if (out_ch.out_z !== want.z)
                begin
                    $error("out_z expected %0d got %0d", want.z, out_ch.out_z);
                    errors++;
                end
                if (out_ch.out_w !== want.w)
                begin
                    $error("out_w expected %0d got %0d", want.w, out_ch.out_w);
                    errors++;
                end
                if (out_ch.used_linear !== want.lin)
                begin
                    $error("used_linear expected %0d got %0d", want.lin, out_ch.used_linear);
                    errors++;
                end
            end
        end
        // stalls: mostly short, now and then a long hold
        if (calm_out)
            out_ch.ready <= 1'b1;
        else if (out_ch.ready)
            out_ch.ready <= ($urandom_range(3) != 0);
        else
            out_ch.ready <= ($urandom_range(($urandom_range(15) == 0) ? 30 : 2) == 0);
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [14:0] thr_list [6] = '{15'd0, qsl_pkg::ONE, 15'd32767, 15'd12000, 15'd16200,
                                      15'd0};
        int          waited;
        errors      = 0;
        threshold   = qsl_pkg::THR_RESET;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.start_x = '0; in_ch.start_y = '0; in_ch.start_z = '0; in_ch.start_w = '0;
        in_ch.end_x   = '0; in_ch.end_y   = '0; in_ch.end_z   = '0; in_ch.end_w   = '0;
        in_ch.blend   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, reset threshold
        // identical unit quaternions: dot is exactly one, linear, start back out
        directed.push_back(row(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 1, 0, 0, 0, 16384, 1));
        // opposite quaternions: start is flipped, then identical
        directed.push_back(row(16384, 0, 0, 0, -16384, 0, 0, 0, 8192, 1, -16384, 0, 0, 0, 1));
        // every component at minus one: dot clamped to one, no saturation beyond -1
        directed.push_back(row(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384,
                               16384, 1, -16384, -16384, -16384, -16384, 1));
        // all components at plus one, blend above one saturates to end
        directed.push_back(row(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
                               32767, 1, 16384, 16384, 16384, 16384, 1));
        // orthogonal pair: spherical path at several blends
        directed.push_back(row(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(16384, 0, 0, 0, 0, 16384, 0, 0, 8192, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(16384, 0, 0, 0, 0, 16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(16384, 0, 0, 0, 0, 16384, 0, 0, 32767, 0, 0, 0, 0, 0, 0));
        // zero quaternions
        directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 0, 0, 0));
        // negative dot on the spherical path
        directed.push_back(row(11585, 11585, 0, 0, -16384, 0, 0, 0, 4096, 0, 0, 0, 0, 0, 0));
        // dot just above and just at the reset threshold
        directed.push_back(row(0, 0, 0, 16384, 0, 0, 362, 16380, 8192, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(0, 0, 0, 16384, 0, 0, 128, 16376, 8192, 0, 0, 0, 0, 0, 0));
        // large non-unit vectors: outputs can saturate
        directed.push_back(row(16384, 16384, -16384, 16384, -16384, 16384, 16384, 16384,
                               12288, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(-16384, 1, -1, 16383, 1, -16384, 16383, -1,
                               1, 0, 0, 0, 0, 0, 0));
        foreach (directed[i])
            send_pair(directed[i]);

        // settings phases, extremes included; random pairs in each
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
                set_threshold((ph == 6) ? 15'($urandom_range(32767)) : thr_list[ph - 1]);
            for (int n = 0; n < 100; n++)
            begin
                if (n % 25 == 0)
                begin
                    calm_in  = ($urandom_range(3) == 0);
                    calm_out = ($urandom_range(3) == 0);
                end
                send_pair(rand_pair());
            end
        end
        in_ch.valid <= 1'b0;
        calm_out = 1'b0;

        // drain, then a further wait so that the pipeline is empty
        waited = 0;
        while (slerp_q.size() != 0 && waited < 200_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (qsl_pkg::LAT + 16) @(posedge clk);
        if (errors == 0 && slerp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            if (slerp_q.size() != 0)
                $error("%0d expected results never arrived", slerp_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
